[rtl/video_register_port_assert.svh]
// assertion macros for the video register port
// used by the port checker
`ifndef VIDEO_REGISTER_PORT_ASSERT_SVH
`define VIDEO_REGISTER_PORT_ASSERT_SVH
`define VRP_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define VRP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[rtl/vrp_pkg.sv]
// shared types and codes of the video register port
// no dependencies
package vrp_pkg;
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_PEEK  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_VBLANK = 2'd3
  } action_t;

  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] reg_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi;
  } out_item_t;
endpackage

[rtl/vrp_front.sv]
// front part: takes items and holds them in a two-entry queue
// depends on vrp_pkg
module vrp_front import vrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_take,
  output in_item_t q_item
);
  in_item_t   buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_valid && q_take;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= in_item;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
    end
  end
endmodule

[rtl/vrp_back.sv]
// back part: register file, video memories and result register
// depends on vrp_pkg
module vrp_back import vrp_pkg::*; #(
  parameter int OAM_BYTES = 256,
  parameter int PATTERN_BYTES = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mirror_mode,
  input  logic      q_valid,
  output logic      q_take,
  input  in_item_t  q_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  localparam int OAW = $clog2(OAM_BYTES);
  localparam int PAW = $clog2(PATTERN_BYTES);

  logic [7:0] oam_mem [OAM_BYTES];
  logic [7:0] pat_mem [PATTERN_BYTES];
  logic [7:0] nt_mem [2048];
  logic [7:0] pal_mem [32];

  logic [7:0]  ctrl_r, mask_r, status_r, oam_index_r, rbuf_r;
  logic        toggle_r;
  logic [2:0]  fine_x_r;
  logic [14:0] temp_r;
  logic [15:0] vaddr_r;

  // stage one reads memory, stage two finishes
  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic [1:0] s1_sel_r;
  logic [7:0] oam_q_r, pat_q_r, nt_q_r, pal_q_r;
  logic       out_valid_r;
  out_item_t  out_r;

  logic       s2_free, s1_go, take;
  logic [13:0] a14;
  logic [10:0] nt_slot;
  logic [4:0]  pal_slot;
  logic [7:0]  mem_val, fresh;
  logic        is_write_data, is_read_data;

  assign out_valid = out_valid_r;
  assign out_item = out_r;
  assign s2_free = !out_valid_r || !out_stall;
  assign s1_go = s1_valid_r && s2_free;
  // only one item in flight so data access sees final address
  assign take = q_valid && (!s1_valid_r || s1_go) && !(s1_valid_r);
  assign q_take = take;

  assign a14 = vaddr_r[13:0];
  assign nt_slot = {mirror_mode ? a14[11] : a14[10], a14[9:0]};
  assign pal_slot = (a14[4:0] & 5'h13) == 5'h10 ? {1'b0, a14[3:0]} : a14[4:0];
  assign is_write_data = q_item.action == ACT_WRITE && q_item.reg_select == REG_DATA;

  always_ff @(posedge clk) begin
    oam_q_r <= oam_mem[oam_index_r[OAW-1:0]];
    pat_q_r <= pat_mem[a14[PAW-1:0]];
    nt_q_r <= nt_mem[nt_slot];
    pal_q_r <= pal_mem[pal_slot];
    if (take && q_item.action == ACT_WRITE) begin
      if (q_item.reg_select == REG_OAMDATA) oam_mem[oam_index_r[OAW-1:0]] <= q_item.write_data;
      if (is_write_data) begin
        if (a14 <= 14'h1FFF) pat_mem[a14[PAW-1:0]] <= q_item.write_data;
        else if (a14 <= 14'h3EFF) nt_mem[nt_slot] <= q_item.write_data;
        else pal_mem[pal_slot] <= q_item.write_data;
      end
    end
    if (take) begin
      s1_item_r <= q_item;
      s1_sel_r <= a14 <= 14'h1FFF ? 2'd0 : (a14 <= 14'h3EFF ? 2'd1 : 2'd2);
    end
  end

  always_comb begin
    case (s1_sel_r)
      2'd0: mem_val = pat_q_r;
      2'd1: mem_val = nt_q_r;
      default: mem_val = pal_q_r & (mask_r[0] ? 8'h30 : 8'h3F);
    endcase
    fresh = mem_val;
    is_read_data = s1_item_r.action == ACT_READ && s1_item_r.reg_select == REG_DATA;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_r.read_data <= 8'h00;
      out_r.nmi <= 1'b0;
      unique case (s1_item_r.action)
        ACT_PEEK: begin
          if (s1_item_r.reg_select == REG_CTRL) out_r.read_data <= ctrl_r;
          else if (s1_item_r.reg_select == REG_MASK) out_r.read_data <= mask_r;
          else if (s1_item_r.reg_select == REG_STATUS) out_r.read_data <= status_r;
        end
        ACT_READ: begin
          if (s1_item_r.reg_select == REG_STATUS)
            out_r.read_data <= {status_r[7:5], rbuf_r[4:0]};
          else if (s1_item_r.reg_select == REG_OAMDATA) out_r.read_data <= oam_q_r;
          else if (is_read_data)
            out_r.read_data <= (s1_sel_r == 2'd2) ? fresh : rbuf_r;
        end
        ACT_VBLANK: out_r.nmi <= ctrl_r[7];
        default: ;
      endcase
    end
    if (!rst_n) begin
      ctrl_r <= '0; mask_r <= '0; status_r <= '0; oam_index_r <= '0;
      rbuf_r <= '0; toggle_r <= 1'b0; fine_x_r <= '0; temp_r <= '0;
      vaddr_r <= '0; s1_valid_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      if (take) s1_valid_r <= 1'b1;
      else if (s1_go) s1_valid_r <= 1'b0;
      if (s1_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (s1_go) begin
        unique case (s1_item_r.action)
          ACT_READ: begin
            if (s1_item_r.reg_select == REG_STATUS) begin
              status_r[7] <= 1'b0;
              toggle_r <= 1'b0;
            end else if (is_read_data) begin
              rbuf_r <= fresh;
              vaddr_r <= vaddr_r + (ctrl_r[2] ? 16'd32 : 16'd1);
            end
          end
          ACT_WRITE: begin
            case (s1_item_r.reg_select)
              REG_CTRL: begin
                ctrl_r <= s1_item_r.write_data;
                temp_r[11:10] <= s1_item_r.write_data[1:0];
              end
              REG_MASK: mask_r <= s1_item_r.write_data;
              REG_OAMADDR: oam_index_r <= s1_item_r.write_data;
              REG_SCROLL: begin
                if (!toggle_r) begin
                  fine_x_r <= s1_item_r.write_data[2:0];
                  temp_r[4:0] <= s1_item_r.write_data[7:3];
                end else begin
                  temp_r[14:12] <= s1_item_r.write_data[2:0];
                  temp_r[9:5] <= s1_item_r.write_data[7:3];
                end
                toggle_r <= !toggle_r;
              end
              REG_ADDR: begin
                if (!toggle_r) begin
                  temp_r[14:8] <= {1'b0, s1_item_r.write_data[5:0]};
                end else begin
                  temp_r[7:0] <= s1_item_r.write_data;
                  vaddr_r <= {1'b0, temp_r[14:8], s1_item_r.write_data};
                end
                toggle_r <= !toggle_r;
              end
              REG_DATA: vaddr_r <= vaddr_r + (ctrl_r[2] ? 16'd32 : 16'd1);
              default: ;
            endcase
          end
          ACT_VBLANK: status_r[7] <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  logic unused_fine;
  assign unused_fine = ^fine_x_r;
endmodule

[rtl/video_register_port.sv]
// top level of the video register port
// depends on vrp_pkg, vrp_front and vrp_back
// Each access passes through the queue entry, the memory read stage and the
// result register, which holds the result. Accesses are carried out one at a
// time: a new access enters the back part only once the previous one has left
// the memory read stage; the queue takes up to two items ahead. Reset is
// synchronous; video memories hold whatever was last written.
module video_register_port import vrp_pkg::*; #(
  parameter int OAM_BYTES = 256,
  parameter int PATTERN_BYTES = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  logic     mirror_r, q_valid, q_take;
  in_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) mirror_r <= 1'b0;
    else if (cfg_we) mirror_r <= cfg_wdata;
  end

  vrp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .q_valid, .q_take, .q_item
  );

  vrp_back #(.OAM_BYTES(OAM_BYTES), .PATTERN_BYTES(PATTERN_BYTES)) u_back (
    .clk, .rst_n, .mirror_mode(mirror_r), .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_item
  );
endmodule

[rtl/vrp_checker.sv]
// port checker for the video register port
// depends on vrp_pkg and video_register_port_assert.svh
`include "video_register_port_assert.svh"
module vrp_checker import vrp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);
  `VRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
  `VRP_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_item))
  `VRP_ASSERT_IMPLY(a_known, clk, rst_n, 1'b1, !$isunknown({in_stall, out_valid}))
  `VRP_ASSERT_IMPLY(a_nmi_data, clk, rst_n, out_valid && out_item.nmi, out_item.read_data == 8'h00)
endmodule

bind video_register_port vrp_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item
);

[tb/sv/video_register_port_checker.sv]
// checker for the video register port: watches both channels, predicts each result
// from its own copy of the register and memory state, compares field by field
// depends on vrp_pkg
module video_register_port_checker import vrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_count
);
  logic        mirror;
  logic [7:0]  ctrl, mask, status, oam_ptr, rbuf;
  logic        toggle;
  logic [2:0]  fine_x;
  logic [14:0] tmp_addr;
  logic [15:0] vaddr;
  logic [7:0]  oam [256];
  logic [7:0]  pattern [8192];
  logic [7:0]  nametable [2048];
  logic [7:0]  palette [32];
  out_item_t   expected_q [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  function automatic int nt_index(logic [13:0] a);
    logic [11:0] off;
    logic        tsel;
    off = a[11:0];
    tsel = mirror ? off[11] : off[10];
    return {tsel, off[9:0]};
  endfunction

  function automatic int pal_index(logic [13:0] a);
    logic [4:0] p;
    p = a[4:0];
    if ((p & 5'h13) == 5'h10) p = p & 5'h0F;
    return p;
  endfunction

  function automatic logic [7:0] vram_fetch(logic [13:0] a);
    if (a <= 14'h1FFF) return pattern[a[12:0]];
    if (a <= 14'h3EFF) return nametable[nt_index(a)];
    return palette[pal_index(a)] & (mask[0] ? 8'h30 : 8'h3F);
  endfunction

  function automatic void vram_store(logic [13:0] a, logic [7:0] v);
    if (a <= 14'h1FFF) pattern[a[12:0]] = v;
    else if (a <= 14'h3EFF) nametable[nt_index(a)] = v;
    else palette[pal_index(a)] = v;
  endfunction

  function automatic void step_addr();
    vaddr = vaddr + (ctrl[2] ? 16'd32 : 16'd1);
  endfunction

  function automatic out_item_t predict_access(in_item_t it);
    out_item_t r;
    logic [7:0] wd;
    r = '0;
    wd = it.write_data;
    case (action_t'(it.action))
      ACT_PEEK: begin
        if (it.reg_select == REG_CTRL) r.read_data = ctrl;
        else if (it.reg_select == REG_MASK) r.read_data = mask;
        else if (it.reg_select == REG_STATUS) r.read_data = status;
      end
      ACT_READ: begin
        if (it.reg_select == REG_STATUS) begin
          r.read_data = {status[7:5], rbuf[4:0]};
          status[7] = 1'b0;
          toggle = 1'b0;
        end else if (it.reg_select == REG_OAMDATA) begin
          r.read_data = oam[oam_ptr];
        end else if (it.reg_select == REG_DATA) begin
          r.read_data = rbuf;
          rbuf = vram_fetch(vaddr[13:0]);
          if (vaddr[13:0] >= 14'h3F00) r.read_data = rbuf;
          step_addr();
        end
      end
      ACT_WRITE: begin
        case (it.reg_select)
          REG_CTRL: begin
            ctrl = wd;
            tmp_addr[11:10] = wd[1:0];
          end
          REG_MASK: mask = wd;
          REG_OAMADDR: oam_ptr = wd;
          REG_OAMDATA: oam[oam_ptr] = wd;
          REG_SCROLL: begin
            if (!toggle) begin
              fine_x = wd[2:0];
              tmp_addr[4:0] = wd[7:3];
            end else begin
              tmp_addr[14:12] = wd[2:0];
              tmp_addr[9:5] = wd[7:3];
            end
            toggle = !toggle;
          end
          REG_ADDR: begin
            if (!toggle) begin
              tmp_addr = {1'b0, wd[5:0], tmp_addr[7:0]};
            end else begin
              tmp_addr[7:0] = wd;
              vaddr = {1'b0, tmp_addr};
            end
            toggle = !toggle;
          end
          REG_DATA: begin
            vram_store(vaddr[13:0], wd);
            step_addr();
          end
          default: ;
        endcase
      end
      default: begin
        status[7] = 1'b1;
        r.nmi = ctrl[7];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mirror = 0; ctrl = 0; mask = 0; status = 0; oam_ptr = 0; rbuf = 0;
      toggle = 0; fine_x = 0; tmp_addr = 0; vaddr = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) mirror = cfg_wdata;
      if (in_valid && !in_stall) expected_q.push_back(predict_access(in_item));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", out_item, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_item.read_data !== want.read_data)
            report_mismatch("read_data", out_item.read_data, want.read_data);
          if (out_item.nmi !== want.nmi) report_mismatch("nmi", out_item.nmi, want.nmi);
        end
      end
    end
    pending_count = expected_q.size();
  end
endmodule

[tb/sv/tb_video_register_port.sv]
// testbench top for the video register port: clock, reset, stimulus and verdict
// depends on vrp_pkg, video_register_port and video_register_port_checker
module tb_video_register_port;
  import vrp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      cfg_we = 0;
  logic      cfg_wdata = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_item;
  int        fail_count, pending_count;
  int        cycles = 0;

  // shadow of the address state, used only to keep reads on written memory
  logic        sh_mirror = 0;
  logic [7:0]  sh_ctrl = 0, sh_oam_ptr = 0;
  logic        sh_toggle = 0;
  logic [14:0] sh_tmp = 0;
  logic [15:0] sh_vaddr = 0;
  bit          oam_w [256];
  bit          pat_w [8192];
  bit          nt_w [2048];
  bit          pal_w [32];
  in_item_t    stim_q [$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  video_register_port dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  video_register_port_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls in four modes that take turns
  always @(posedge clk) begin
    case ((cycles / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= cycles[2];
    endcase
  end

  function automatic bit shadow_written(logic [13:0] a, bit mark);
    logic [11:0] off;
    logic [4:0]  p;
    int          k;
    if (a <= 14'h1FFF) begin
      if (mark) pat_w[a[12:0]] = 1;
      return pat_w[a[12:0]];
    end
    if (a <= 14'h3EFF) begin
      off = a[11:0];
      k = {(sh_mirror ? off[11] : off[10]), off[9:0]};
      if (mark) nt_w[k] = 1;
      return nt_w[k];
    end
    p = a[4:0];
    if ((p & 5'h13) == 5'h10) p = p & 5'h0F;
    if (mark) pal_w[p] = 1;
    return pal_w[p];
  endfunction

  task automatic add_item(action_t act, logic [2:0] rsel, logic [7:0] wd);
    in_item_t it;
    bit       w;
    if (act == ACT_READ && rsel == REG_OAMDATA && !oam_w[sh_oam_ptr]) act = ACT_WRITE;
    if (act == ACT_READ && rsel == REG_DATA && !shadow_written(sh_vaddr[13:0], 0))
      act = ACT_WRITE;
    it.action = act;
    it.reg_select = rsel;
    it.write_data = wd;
    stim_q.push_back(it);
    if (act == ACT_READ) begin
      if (rsel == REG_STATUS) sh_toggle = 0;
      if (rsel == REG_DATA) sh_vaddr += sh_ctrl[2] ? 16'd32 : 16'd1;
    end else if (act == ACT_WRITE) begin
      case (rsel)
        REG_CTRL: begin
          sh_ctrl = wd;
          sh_tmp[11:10] = wd[1:0];
        end
        REG_OAMADDR: sh_oam_ptr = wd;
        REG_OAMDATA: oam_w[sh_oam_ptr] = 1;
        REG_SCROLL: begin
          if (!sh_toggle) sh_tmp[4:0] = wd[7:3];
          else begin
            sh_tmp[14:12] = wd[2:0];
            sh_tmp[9:5] = wd[7:3];
          end
          sh_toggle = !sh_toggle;
        end
        REG_ADDR: begin
          if (!sh_toggle) sh_tmp = {1'b0, wd[5:0], sh_tmp[7:0]};
          else begin
            sh_tmp[7:0] = wd;
            sh_vaddr = {1'b0, sh_tmp};
          end
          sh_toggle = !sh_toggle;
        end
        REG_DATA: begin
          w = shadow_written(sh_vaddr[13:0], 1);
          sh_vaddr += sh_ctrl[2] ? 16'd32 : 16'd1;
        end
        default: ;
      endcase
    end
  endtask

  task automatic set_vaddr(logic [15:0] a);
    add_item(ACT_READ, REG_STATUS, 8'h00);
    add_item(ACT_WRITE, REG_ADDR, a[15:8]);
    add_item(ACT_WRITE, REG_ADDR, a[7:0]);
  endtask

  task automatic add_directed();
    logic [2:0] r;
    for (int i = 0; i < 8; i++) begin
      r = 3'(i);
      add_item(ACT_PEEK, r, 8'hFF);
    end
    add_item(ACT_WRITE, REG_CTRL, 8'hFF);
    add_item(ACT_VBLANK, REG_CTRL, 8'h00);
    add_item(ACT_PEEK, REG_STATUS, 8'h00);
    add_item(ACT_READ, REG_STATUS, 8'h00);
    add_item(ACT_WRITE, REG_CTRL, 8'h00);
    add_item(ACT_VBLANK, REG_DATA, 8'hFF);
    add_item(ACT_WRITE, REG_STATUS, 8'hFF);
    add_item(ACT_WRITE, REG_MASK, 8'hFF);
    add_item(ACT_WRITE, REG_OAMADDR, 8'hFF);
    add_item(ACT_WRITE, REG_OAMDATA, 8'hFF);
    add_item(ACT_READ, REG_OAMDATA, 8'h00);
    add_item(ACT_WRITE, REG_SCROLL, 8'hFF);
    add_item(ACT_WRITE, REG_SCROLL, 8'h00);
    set_vaddr(16'hFF10);
    add_item(ACT_WRITE, REG_DATA, 8'hFF);
    set_vaddr(16'h3F00);
    add_item(ACT_READ, REG_DATA, 8'h00);
    add_item(ACT_WRITE, REG_MASK, 8'h00);
    set_vaddr(16'h3F00);
    add_item(ACT_READ, REG_DATA, 8'h00);
    add_item(ACT_READ, REG_CTRL, 8'h00);
    add_item(ACT_READ, REG_ADDR, 8'h00);
  endtask

  task automatic add_random(int count);
    int          n, pick;
    logic [15:0] base;
    while (stim_q.size() < count) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        add_item(ACT_WRITE, REG_CTRL, 8'($urandom));
        case ($urandom_range(0, 3))
          0: base = 16'($urandom_range(16'h0000, 16'h1FFF));
          1: base = 16'($urandom_range(16'h2000, 16'h3EFF));
          2: base = 16'($urandom_range(16'h3F00, 16'h3FFF));
          default: base = 16'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) base[15:14] = 2'($urandom);
        n = $urandom_range(1, 8);
        set_vaddr(base);
        repeat (n) add_item(ACT_WRITE, REG_DATA, 8'($urandom));
        set_vaddr(base);
        repeat (n + 1) add_item(ACT_READ, REG_DATA, 8'h00);
      end else if (pick == 4) begin
        add_item(ACT_WRITE, REG_OAMADDR, 8'($urandom));
        add_item(ACT_WRITE, REG_OAMDATA, 8'($urandom));
        add_item(ACT_READ, REG_OAMDATA, 8'($urandom));
      end else if (pick == 5) begin
        add_item(ACT_WRITE, REG_SCROLL, 8'($urandom));
        add_item(ACT_WRITE, REG_SCROLL, 8'($urandom));
      end else if (pick == 6) begin
        add_item(ACT_VBLANK, 3'($urandom), 8'($urandom));
        add_item(ACT_READ, REG_STATUS, 8'($urandom));
      end else if (pick == 7) begin
        add_item(ACT_WRITE, REG_MASK, 8'($urandom));
        add_item(ACT_PEEK, 3'($urandom), 8'($urandom));
      end else begin
        add_item(action_t'(2'($urandom_range(0, 3))), 3'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic send_all();
    in_item_t it;
    int       burst;
    while (stim_q.size() != 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && stim_q.size() != 0) begin
        it = stim_q.pop_front();
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mirror(logic m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_mirror = m;
    @(posedge clk);
  endtask

  initial begin
    logic m_seq [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_directed();
    send_all();
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      write_mirror(m_seq[ph]);
      add_random(240);
      send_all();
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[video_register_port.f]
+incdir+rtl
rtl/vrp_pkg.sv
rtl/vrp_front.sv
rtl/vrp_back.sv
rtl/video_register_port.sv
rtl/vrp_checker.sv
tb/sv/video_register_port_checker.sv
tb/sv/tb_video_register_port.sv
